@@ design/cfd_pkg.sv @@
// Shared types and constants for the connection flood detector.
// No dependencies; imported by cfd_cell and connection_flood_detector_top.
package cfd_pkg;

  localparam int unsigned TableEntriesDefault = 64;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = AddrW + TimeW;
  localparam int unsigned OutDataW = 16;

  localparam logic [TimeW-1:0]  ExpiryReset = 32'd40000;
  localparam logic [CountW-1:0] LimitReset  = 8'd2;
  localparam logic [CountW-1:0] CountMax    = 8'd255;
  localparam logic [CountW-1:0] CountOne    = 8'd1;

  localparam logic [CfgIdxW-1:0] RegExpiryWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFloodLimit   = 2'd1;

  // lookup token passed from cell to cell
  typedef struct packed {
    logic              active;
    logic              hit;
    logic              taken;
    logic [CountW-1:0] count;
  } cfd_tok_t;

  // request fields broadcast to every cell during a scan
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] window;
  } cfd_req_t;

  // end-of-scan control broadcast to every cell
  typedef struct packed {
    logic finish;
    logic insert;
  } cfd_ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } cfd_state_e;

endpackage

@@ design/connection_flood_detector_top.sv @@
// Top level of the connection flood detector: stream ports, registers, cell chain.
// Depends on cfd_pkg and cfd_cell.
//
// Each request is one connection attempt (source address, time in ms). A lookup
// token walks the chain of TABLE_ENTRIES cells, one cell per cycle; each cell
// expires, matches or reserves its own entry as the token passes. A request goes
// from acceptance through the start register and the TABLE_ENTRIES cell registers
// into the result register. The next request is taken once the previous result
// has moved into the output register, where it may still wait, so no new request
// is accepted while one is still in the chain or while its result stalls.
// The table is empty after reset. Configuration writes are taken at any time
// but must only be issued while no request is in flight.
module connection_flood_detector_top #(
  parameter int unsigned TABLE_ENTRIES = cfd_pkg::TableEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // [31:0] source_address, [63:32] now_ms
  input  logic [cfd_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] flooding, [8:1] attempt_count, [9] table_full_drop, [15:10] zero
  output logic [cfd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cfd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cfd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cfd_pkg::*;

  cfd_state_e        state_q, state_d;
  logic              start_q;
  logic [AddrW-1:0]  addr_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  window_q;
  logic [CountW-1:0] limit_q;
  cfd_tok_t          res_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic              accept, emit;
  cfd_req_t          req;
  cfd_ctrl_t         ctrl;
  cfd_tok_t          tok [TABLE_ENTRIES+1];

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (s_axis_tvalid) state_d = StScan;
      StScan: if (tok[TABLE_ENTRIES].active) state_d = StDone;
      StDone: if (emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == StIdle);
    emit          = (state_q == StDone) && (!out_valid_q || m_axis_tready);
    ctrl.finish   = emit;
    ctrl.insert   = !res_q.hit && res_q.taken;
  end

  always_comb begin
    out_data_d = '0;
    if (res_q.hit) begin
      out_data_d[0]          = (res_q.count > limit_q);
      out_data_d[CountW:1]   = res_q.count;
    end else if (res_q.taken) begin
      out_data_d[CountW:1]   = CountOne;
    end else begin
      out_data_d[CountW+1]   = 1'b1;
    end
  end

  assign req.addr   = addr_q;
  assign req.now    = now_q;
  assign req.window = window_q;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = start_q;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cfd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req),
      .ctrl_i (ctrl),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= ExpiryReset;
      limit_q     <= LimitReset;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegExpiryWindow: window_q <= cfg_data_i;
          RegFloodLimit:   limit_q  <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= s_axis_tdata[AddrW-1:0];
      now_q  <= s_axis_tdata[InDataW-1:AddrW];
    end
    if (tok[TABLE_ENTRIES].active) begin
      res_q <= tok[TABLE_ENTRIES];
    end
    if (emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/cfd_cell.sv @@
// One table entry of the connection flood detector with its share of the lookup.
// Depends on cfd_pkg; instantiated as a chain by connection_flood_detector_top.
module cfd_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfd_pkg::cfd_req_t  req_i,
  input  cfd_pkg::cfd_ctrl_t ctrl_i,
  input  cfd_pkg::cfd_tok_t  tok_i,
  output cfd_pkg::cfd_tok_t  tok_o
);
  import cfd_pkg::*;

  logic              valid_q, valid_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  addr_q;
  logic [CountW-1:0] count_q, count_inc;
  logic [TimeW-1:0]  last_q;
  cfd_tok_t          tok_q, tok_d;
  logic              expired, live, match, free;

  assign expired = valid_q &&
                   ({1'b0, req_i.now} > ({1'b0, last_q} + {1'b0, req_i.window}));
  assign live    = valid_q && !expired;
  assign match   = tok_i.active && live && (addr_q == req_i.addr) && !tok_i.hit;
  assign free    = tok_i.active && !live && !tok_i.taken;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + CountOne;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    if (tok_i.active && expired) begin
      valid_d = 1'b0;
    end
    if (free) begin
      pend_d = 1'b1;
    end
    if (ctrl_i.finish) begin
      if (ctrl_i.insert && pend_q) begin
        valid_d = 1'b1;
      end
      pend_d = 1'b0;
    end
  end

  always_comb begin
    tok_d        = tok_i;
    tok_d.hit    = tok_i.hit | match;
    tok_d.taken  = tok_i.taken | free;
    tok_d.count  = match ? count_inc : tok_i.count;
    tok_d.active = tok_i.active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      count_q <= count_inc;
      last_q  <= req_i.now;
    end else if (free) begin
      addr_q  <= req_i.addr;
      count_q <= CountOne;
      last_q  <= req_i.now;
    end
  end

  assign tok_o = tok_q;

endmodule
